FILE: rtl/fir_full_convolution_core_macros.svh
// ----------------------------------------------------------------------------
// FIR full convolution core assertion macros
// Property shorthands clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FIR_FULL_CONVOLUTION_CORE_MACROS_SVH
`define FIR_FULL_CONVOLUTION_CORE_MACROS_SVH

// overlapping implication
`define FFC_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> cons) else $error(msg);

// next-cycle implication
`define FFC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/ffc_pkg.sv
// ----------------------------------------------------------------------------
// FIR full convolution package
// Shared constants, field layout and control types.
// ----------------------------------------------------------------------------
`default_nettype none

package ffc_pkg;

   localparam int MAX_TAPS_DEF     = 16;
   localparam int SAMPLE_WIDTH_DEF = 16;

   localparam int TAP_INDEX_WIDTH  = 4;
   localparam int FIELD_WIDTH      = 16;
   localparam int RESULT_WIDTH     = 36;
   localparam int TAP_COUNT_WIDTH  = 5;

   localparam int TAP_INDEX_LSB    = 0;
   localparam int COEF_LSB         = TAP_INDEX_LSB + TAP_INDEX_WIDTH;
   localparam int SAMPLE_LSB       = COEF_LSB + FIELD_WIDTH;
   localparam int REQ_FIELDS_WIDTH = SAMPLE_LSB + FIELD_WIDTH;
   localparam int REQ_DATA_WIDTH   = ((REQ_FIELDS_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH   = ((RESULT_WIDTH + 7) / 8) * 8;

   localparam logic [TAP_COUNT_WIDTH-1:0] TAP_COUNT_RESET = 5'd16;

   localparam logic KIND_COEF   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef struct packed {
      logic clear;
      logic step;
      logic active;
   } mac_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/ffc_mac.sv
// ----------------------------------------------------------------------------
// FIR shared multiply-accumulate unit
// Registered product stage followed by a modular accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module ffc_mac #(
   parameter int SAMPLE_WIDTH = ffc_pkg::SAMPLE_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire ffc_pkg::mac_ctl_type              ctl,
   input  wire logic [SAMPLE_WIDTH-1:0]           coef,
   input  wire logic [SAMPLE_WIDTH-1:0]           smp,
   output logic      [ffc_pkg::RESULT_WIDTH-1:0]  acc,
   output logic                                   busy
);

   localparam int PW = 2 * SAMPLE_WIDTH;
   localparam int RW = ffc_pkg::RESULT_WIDTH;

   logic signed [PW-1:0]    prod_ff;
   logic signed [PW-1:0]    prod_in;
   logic                    prod_act_ff;
   logic [RW-1:0]           acc_ff;
   logic [RW-1:0]           acc_in;
   logic [PW+RW-1:0]        prod_wide;

   assign prod_in   = $signed(coef) * $signed(smp);
   assign prod_wide = {{RW{prod_ff[PW-1]}}, prod_ff};

   always_comb begin
      acc_in = acc_ff;
      priority if (ctl.clear) begin
         acc_in = '0;
      end else if (prod_act_ff) begin
         acc_in = acc_ff + prod_wide[RW-1:0];
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_act_ff <= 1'b0;
      end else begin
         prod_act_ff <= ctl.step && ctl.active;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc  = acc_ff;
   assign busy = prod_act_ff;

endmodule

`default_nettype wire

FILE: rtl/fir_full_convolution_core.sv
// ----------------------------------------------------------------------------
// FIR full convolution core
// Streaming direct-form FIR giving the full linear convolution of a signal.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: tuser selects the transaction kind. A coefficient transaction
//   writes one tap and leaves req_tready high. A sample transaction shifts the
//   delay line and yields one result; tlast on a sample also flushes the tail
//   with tap_count-1 further results from zero input (tap_count clamped to
//   1..MAX_TAPS), the final one with tlast. rsp channel: one 36-bit Q6.30
//   result per sample and per tail step, tlast on the final. csr port:
//   csr_wr_en writes tap_count. The user must write it only while the core
//   is idle; the core does not enforce this. One multiplier is shared over
//   all MAX_TAPS delay positions; each tap passes the operand, product
//   and accumulator registers, and a result is loaded into the rsp register
//   once the MAC is idle and rsp is free. req_tready is low from a sample
//   transaction until its last result is loaded into the output register
//   and rises with it. A stalled rsp holds the result; the core waits to
//   load the next one and still takes a new transaction while the last
//   result waits. Reset clears the delay line, sets tap_count to 16 and
//   empties rsp; the tap store holds garbage until written.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_full_convolution_core #(
   parameter int MAX_TAPS     = ffc_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_WIDTH = ffc_pkg::SAMPLE_WIDTH_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // tap_index, coefficient, sample, zero pad
   input  wire logic [ffc_pkg::REQ_DATA_WIDTH-1:0]     req_tdata,
   // kind
   input  wire logic                                   req_tuser,
   input  wire logic                                   req_tlast,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // result, zero pad
   output logic      [ffc_pkg::RSP_DATA_WIDTH-1:0]     rsp_tdata,
   output logic                                        rsp_tlast,
   input  wire logic                                   csr_wr_en,
   input  wire logic [ffc_pkg::TAP_COUNT_WIDTH-1:0]    csr_wr_data
);

   localparam int SW  = SAMPLE_WIDTH;
   localparam int FW  = ffc_pkg::FIELD_WIDTH;
   localparam int IW  = ffc_pkg::TAP_INDEX_WIDTH;
   localparam int RW  = ffc_pkg::RESULT_WIDTH;
   localparam int AW  = $clog2(MAX_TAPS);
   localparam int CW  = $clog2(MAX_TAPS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   state_type                          state_ff, state_in;
   logic [ffc_pkg::TAP_COUNT_WIDTH-1:0] tap_count_ff;
   logic [CW-1:0]                      taps_ff, taps_in;
   logic [CW-1:0]                      k_ff, k_in;
   logic [CW-1:0]                      flush_ff, flush_in;
   logic                               last_ff, last_in;
   logic [SW-1:0]                      window_ff [MAX_TAPS];
   logic [SW-1:0]                      window_in [MAX_TAPS];
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_last_ff, rsp_last_in;
   logic [RW-1:0]                      rsp_data_ff, rsp_data_in;

   logic [SW-1:0]                      tap_mem [MAX_TAPS];
   logic [SW-1:0]                      tap_rd_ff;
   logic [SW-1:0]                      smp_ff;
   logic                               opnd_act_ff;
   logic                               opnd_use_ff;

   logic [IW-1:0]                      idx_field;
   logic [FW-1:0]                      coef_field;
   logic [FW-1:0]                      smp_field;
   logic [IW+AW-1:0]                   idx_ext;
   logic [FW+SW-1:0]                   coef_ext;
   logic [FW+SW-1:0]                   smp_ext;
   logic [SW-1:0]                      smp_val;
   logic [CW-1:0]                      taps_eff;
   logic                               req_accept;
   logic                               mem_we;
   logic                               rsp_free;
   logic                               mac_busy;
   logic                               unit_busy;
   logic [RW-1:0]                      acc;
   ffc_pkg::mac_ctl_type               mac_ctl;

   assign idx_field  = req_tdata[ffc_pkg::TAP_INDEX_LSB +: IW];
   assign coef_field = req_tdata[ffc_pkg::COEF_LSB +: FW];
   assign smp_field  = req_tdata[ffc_pkg::SAMPLE_LSB +: FW];
   assign idx_ext    = {{AW{1'b0}}, idx_field};
   assign coef_ext   = {{SW{1'b0}}, coef_field};
   assign smp_ext    = {{SW{1'b0}}, smp_field};
   assign smp_val    = smp_ext[SW-1:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign mem_we     = req_accept && (req_tuser == ffc_pkg::KIND_COEF)
                       && (int'(idx_field) < MAX_TAPS);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign unit_busy  = opnd_act_ff || mac_busy;

   always_comb begin
      priority if (tap_count_ff == '0) begin
         taps_eff = CW'(1);
      end else if (int'(tap_count_ff) > MAX_TAPS) begin
         taps_eff = CW'(MAX_TAPS);
      end else begin
         taps_eff = CW'(tap_count_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      taps_in      = taps_ff;
      k_in         = k_ff;
      flush_in     = flush_ff;
      last_in      = last_ff;
      window_in    = window_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_data_in  = rsp_data_ff;
      mac_ctl      = '0;
      mac_ctl.step   = opnd_act_ff;
      mac_ctl.active = opnd_use_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_tuser == ffc_pkg::KIND_SAMPLE)) begin
               window_in[0] = smp_val;
               for (int i = 1; i < MAX_TAPS; i++) begin
                  window_in[i] = window_ff[i-1];
               end
               taps_in       = taps_eff;
               k_in          = '0;
               flush_in      = req_tlast ? (taps_eff - CW'(1)) : '0;
               last_in       = req_tlast;
               mac_ctl.clear = 1'b1;
               state_in      = ST_RUN;
            end
         end
         ST_RUN: begin
            for (int i = 0; i < MAX_TAPS - 1; i++) begin
               window_in[i] = window_ff[i+1];
            end
            window_in[MAX_TAPS-1] = window_ff[0];
            k_in = k_ff + CW'(1);
            if (k_ff == CW'(MAX_TAPS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!unit_busy && rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc;
               rsp_last_in  = last_ff && (flush_ff == '0);
               if (flush_ff != '0) begin
                  flush_in     = flush_ff - CW'(1);
                  window_in[0] = '0;
                  for (int i = 1; i < MAX_TAPS; i++) begin
                     window_in[i] = window_ff[i-1];
                  end
                  k_in          = '0;
                  mac_ctl.clear = 1'b1;
                  state_in      = ST_RUN;
               end else begin
                  if (last_ff) begin
                     window_in = '{default: '0};
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         taps_ff      <= '0;
         k_ff         <= '0;
         flush_ff     <= '0;
         last_ff      <= 1'b0;
         window_ff    <= '{default: '0};
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
         rsp_data_ff  <= '0;
         opnd_act_ff  <= 1'b0;
         opnd_use_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         taps_ff      <= taps_in;
         k_ff         <= k_in;
         flush_ff     <= flush_in;
         last_ff      <= last_in;
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
         rsp_data_ff  <= rsp_data_in;
         opnd_act_ff  <= (state_ff == ST_RUN);
         opnd_use_ff  <= (k_ff < taps_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= ffc_pkg::TAP_COUNT_RESET;
      end else if (csr_wr_en) begin
         tap_count_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff <= window_ff[0];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tap_mem[idx_ext[AW-1:0]] <= coef_ext[SW-1:0];
      end
      tap_rd_ff <= tap_mem[k_ff[AW-1:0]];
   end

   ffc_mac #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .coef  (tap_rd_ff),
      .smp   (smp_ff),
      .acc   (acc),
      .busy  (mac_busy)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(ffc_pkg::RSP_DATA_WIDTH - RW){1'b0}}, rsp_data_ff};

endmodule

`default_nettype wire

FILE: rtl/ffc_checker.sv
// ----------------------------------------------------------------------------
// FIR full convolution port checker
// Port-level properties of the convolution core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fir_full_convolution_core_macros.svh"

module ffc_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic                                req_tuser,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [ffc_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input wire logic                                rsp_tlast
);

   logic req_accept;

   assign req_accept = req_tvalid && req_tready;

   `FFC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp changed while stalled")

   `FFC_ASSERT_NEXT(a_sample_busy, req_accept && (req_tuser == ffc_pkg::KIND_SAMPLE), !req_tready, "ready after sample transaction")

   `FFC_ASSERT_IMPL(a_coef_ready, req_accept && (req_tuser == ffc_pkg::KIND_COEF), ##1 req_tready, "not ready after coefficient transaction")

endmodule

bind fir_full_convolution_core ffc_checker u_ffc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
